[rtl/slcd_pkg.sv]
// Package for the sync/length/checksum deframer.
// Holds the queue item type, field widths, register indexes and reset values.
// It has no dependencies; every module of the block uses it.
package slcd_pkg;

   localparam int BYTE_W    = 8;
   localparam int INDEX_W   = 4;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_RX = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SYNC_TX = 1'b1;

   localparam logic [BYTE_W-1:0] SYNC_RX_RESET = 8'hA5;
   localparam logic [BYTE_W-1:0] SYNC_TX_RESET = 8'hA4;

   typedef struct packed {
      logic [BYTE_W-1:0] data;
      logic              sync_hit;
   } item_type;

endpackage

[rtl/slcd_front.sv]
// Front end of the deframer: sync value registers and byte classification.
// Tags each received byte with a sync match flag for the parser.
// Depends on slcd_pkg.
module slcd_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [slcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [slcd_pkg::BYTE_W-1:0]    csr_wdata,
   input  logic                           req_valid,
   input  logic [slcd_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                           push_valid,
   output slcd_pkg::item_type             push_item
);

   logic [slcd_pkg::BYTE_W-1:0] sync_rx_ff;
   logic [slcd_pkg::BYTE_W-1:0] sync_tx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_rx_ff <= slcd_pkg::SYNC_RX_RESET;
         sync_tx_ff <= slcd_pkg::SYNC_TX_RESET;
      end else if (csr_we) begin
         case (csr_index)
            slcd_pkg::CSR_SYNC_RX: sync_rx_ff <= csr_wdata;
            slcd_pkg::CSR_SYNC_TX: sync_tx_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign push_valid         = req_valid;
   assign push_item.data     = req_rx_byte;
   assign push_item.sync_hit = (req_rx_byte == sync_rx_ff) || (req_rx_byte == sync_tx_ff);

endmodule

[rtl/slcd_queue.sv]
// Short queue between the classifying front end and the frame parser.
// Lets the input side and the parser stall independently.
// Depends on slcd_pkg.
module slcd_queue #(
   parameter int DEPTH = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   input  slcd_pkg::item_type push_item,
   output logic               full,
   output logic               pop_valid,
   output slcd_pkg::item_type pop_item,
   input  logic               pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   slcd_pkg::item_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   head_ff;
   logic [PTR_W-1:0]   tail_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push;
   logic               do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_item  = slot_ff[head_ff];
   assign do_push   = push_valid && !full;
   assign do_pop    = pop && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (do_push) begin
            tail_ff <= (tail_ff == PTR_W'(DEPTH - 1)) ? '0 : tail_ff + PTR_W'(1);
         end
         if (do_pop) begin
            head_ff <= (head_ff == PTR_W'(DEPTH - 1)) ? '0 : head_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
      if (do_push) begin
         slot_ff[tail_ff] <= push_item;
      end
   end

endmodule

[rtl/slcd_core.sv]
// Frame parser of the deframer: frame buffer, running checksum, replay and output.
// Replays buffered bytes after a failed frame and shifts good frames out.
// Depends on slcd_pkg.
module slcd_core #(
   parameter int MAX_PAYLOAD = 12
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_valid,
   input  slcd_pkg::item_type          q_item,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [slcd_pkg::BYTE_W-1:0] rsp_frame_byte,
   output logic [slcd_pkg::INDEX_W-1:0] rsp_byte_index,
   output logic                        rsp_last
);

   localparam int FRAME_MAX = MAX_PAYLOAD + 4;
   localparam int IDX_W     = $clog2(FRAME_MAX);
   localparam int CNT_W     = $clog2(FRAME_MAX + 1);
   localparam int BW        = slcd_pkg::BYTE_W;
   localparam int IW        = slcd_pkg::INDEX_W;

   typedef enum logic {
      S_PARSE,
      S_EMIT
   } state_type;

   state_type          state_ff, state_in;
   slcd_pkg::item_type store_ff [FRAME_MAX];
   slcd_pkg::item_type store_in [FRAME_MAX];
   slcd_pkg::item_type wr_store [FRAME_MAX];
   logic [IDX_W-1:0]   fill_ff, fill_in;
   logic [CNT_W-1:0]   tot_ff, tot_in;
   logic [CNT_W-1:0]   tot_step;
   logic [BW-1:0]      xor_ff, xor_in;
   logic [IDX_W-1:0]   emit_cnt_ff, emit_cnt_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0]      rsp_byte_ff, rsp_byte_in;
   logic [IW-1:0]      rsp_idx_ff, rsp_idx_in;
   logic               rsp_last_ff, rsp_last_in;
   logic               replay;
   slcd_pkg::item_type cur;
   logic               len_bad;
   logic               chk_hit;
   logic               shift;

   assign replay  = (CNT_W'(fill_ff) != tot_ff);
   assign cur     = replay ? store_ff[fill_ff] : q_item;
   assign len_bad = (fill_ff == IDX_W'(1)) && (cur.data > BW'(MAX_PAYLOAD));
   assign chk_hit = (fill_ff >= IDX_W'(3))
                    && (9'(fill_ff) == ({1'b0, store_ff[1].data} + 9'd3));

   always_comb begin
      state_in     = state_ff;
      fill_in      = fill_ff;
      tot_in       = tot_ff;
      xor_in       = xor_ff;
      emit_cnt_in  = emit_cnt_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_byte_in  = rsp_byte_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;
      shift        = 1'b0;
      tot_step     = tot_ff;
      wr_store     = store_ff;
      case (state_ff)
         S_PARSE: begin
            if (replay || q_valid) begin
               q_pop = !replay;
               if (!replay) begin
                  tot_step = tot_ff + CNT_W'(1);
               end
               wr_store[fill_ff] = cur;
               if (fill_ff == '0) begin
                  if (cur.sync_hit) begin
                     fill_in = IDX_W'(1);
                     xor_in  = cur.data;
                  end else begin
                     shift = 1'b1;
                  end
               end else if (len_bad) begin
                  shift   = 1'b1;
                  fill_in = '0;
                  xor_in  = '0;
               end else if (chk_hit) begin
                  if (cur.data == xor_ff) begin
                     state_in    = S_EMIT;
                     emit_cnt_in = '0;
                  end else begin
                     shift   = 1'b1;
                     fill_in = '0;
                     xor_in  = '0;
                  end
               end else begin
                  xor_in  = xor_ff ^ cur.data;
                  fill_in = fill_ff + IDX_W'(1);
               end
               tot_in = shift ? (tot_step - CNT_W'(1)) : tot_step;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = store_ff[0].data;
               rsp_idx_in   = IW'(emit_cnt_ff);
               rsp_last_in  = (emit_cnt_ff == fill_ff);
               shift        = 1'b1;
               tot_in       = tot_ff - CNT_W'(1);
               emit_cnt_in  = emit_cnt_ff + IDX_W'(1);
               if (emit_cnt_ff == fill_ff) begin
                  state_in = S_PARSE;
                  fill_in  = '0;
                  xor_in   = '0;
               end
            end
         end
         default: begin
            state_in = S_PARSE;
         end
      endcase
      for (int i = 0; i < FRAME_MAX - 1; i++) begin
         store_in[i] = shift ? wr_store[i + 1] : wr_store[i];
      end
      store_in[FRAME_MAX - 1] = wr_store[FRAME_MAX - 1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_PARSE;
         fill_ff      <= '0;
         tot_ff       <= '0;
         xor_ff       <= '0;
         emit_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         tot_ff       <= tot_in;
         xor_ff       <= xor_in;
         emit_cnt_ff  <= emit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      store_ff    <= store_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_idx_ff  <= rsp_idx_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_frame_byte = rsp_byte_ff;
   assign rsp_byte_index = rsp_idx_ff;
   assign rsp_last       = rsp_last_ff;

   a_tot_bound: assert property (@(posedge clock) disable iff (reset)
      tot_ff <= CNT_W'(FRAME_MAX))
      else $error("Frame buffer holds more bytes than it has entries.");

   a_fill_le_tot: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PARSE) |-> (CNT_W'(fill_ff) <= tot_ff))
      else $error("Open frame is longer than the buffered bytes.");

   a_idle_xor: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PARSE && fill_ff == '0) |-> (xor_ff == '0))
      else $error("Running checksum is not clear while hunting for sync.");

   a_emit_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EMIT && (!rsp_valid_ff || !rsp_stall) && emit_cnt_ff == fill_ff)
      |=> (state_ff == S_PARSE && fill_ff == '0 && rsp_valid_ff && rsp_last_ff))
      else $error("Frame output did not end on its checksum byte.");

endmodule

[rtl/sync_len_checksum_deframer.sv]
// Top level of the sync/length/checksum deframer.
// Instantiates slcd_front, slcd_queue and slcd_core; depends on slcd_pkg.
//
//   Channel   Direction  Handshake               Payload
//   req       in         req_valid / req_stall   req_rx_byte
//   rsp       out        rsp_valid / rsp_stall   rsp_frame_byte, rsp_byte_index, rsp_last
//   csr       in         csr_we                  csr_index, csr_wdata
//
// While parsing, the parser takes one byte per cycle, from the queue or from its frame buffer.
// A good frame leaves one byte per cycle while rsp_stall is low; no byte is parsed meanwhile.
// After a failed frame the buffered bytes behind the dropped sync are parsed again,
// one per cycle, and no new byte is taken from the queue meanwhile.
// Reset is synchronous and clears control state; the sync registers return to A5h and A4h.
// req_stall rises only when the input queue is full.
module sync_len_checksum_deframer #(
   parameter int MAX_PAYLOAD = 12,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [slcd_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [slcd_pkg::BYTE_W-1:0]    csr_wdata,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [slcd_pkg::BYTE_W-1:0]    req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [slcd_pkg::BYTE_W-1:0]    rsp_frame_byte,
   output logic [slcd_pkg::INDEX_W-1:0]   rsp_byte_index,
   output logic                           rsp_last
);

   logic               push_valid;
   slcd_pkg::item_type push_item;
   logic               q_full;
   logic               q_valid;
   slcd_pkg::item_type q_item;
   logic               q_pop;

   slcd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .req_valid   (req_valid),
      .req_rx_byte (req_rx_byte),
      .push_valid  (push_valid),
      .push_item   (push_item)
   );

   slcd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_item  (push_item),
      .full       (q_full),
      .pop_valid  (q_valid),
      .pop_item   (q_item),
      .pop        (q_pop)
   );

   slcd_core #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_byte_index (rsp_byte_index),
      .rsp_last       (rsp_last)
   );

   assign req_stall = q_full;

endmodule

[tb/sync_len_checksum_deframer_tb.sv]
// Self-checking testbench for sync_len_checksum_deframer.
// Drives sync-framed byte streams under several sync register settings and checks every
// deframed byte against an in-bench frame parser; depends on slcd_pkg and the RTL only.
module sync_len_checksum_deframer_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_PAYLOAD    = 12;
   localparam int FRAME_MAX      = MAX_PAYLOAD + 4;
   localparam int SETTLE_CYCLES  = 64;
   localparam int HOLD_CYCLES    = 240;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_BYTES    = 14;

   typedef enum int {FRAME_GOOD, FRAME_BAD_SUM, FRAME_LONG, FRAME_CUT} frame_kind_type;

   typedef struct packed {
      logic [slcd_pkg::BYTE_W-1:0]  data;
      logic [slcd_pkg::INDEX_W-1:0] index;
      logic                         last;
   } frame_byte_type;

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           csr_we = 1'b0;
   logic [slcd_pkg::CSR_IDX_W-1:0] csr_index = slcd_pkg::CSR_SYNC_RX;
   logic [slcd_pkg::BYTE_W-1:0]    csr_wdata = '0;
   logic                           req_valid = 1'b0;
   logic                           req_stall;
   logic [slcd_pkg::BYTE_W-1:0]    req_rx_byte = '0;
   logic                           rsp_valid;
   logic                           rsp_stall = 1'b0;
   logic [slcd_pkg::BYTE_W-1:0]    rsp_frame_byte;
   logic [slcd_pkg::INDEX_W-1:0]   rsp_byte_index;
   logic                           rsp_last;

   logic [slcd_pkg::BYTE_W-1:0] sync_rx_cfg = slcd_pkg::SYNC_RX_RESET;
   logic [slcd_pkg::BYTE_W-1:0] sync_tx_cfg = slcd_pkg::SYNC_TX_RESET;
   logic [slcd_pkg::BYTE_W-1:0] frame_buf [FRAME_MAX];
   int                          frame_fill = 0;
   logic [slcd_pkg::BYTE_W-1:0] frame_xor = '0;

   logic [slcd_pkg::BYTE_W-1:0] rx_pending [$];
   frame_byte_type              expected_frame_bytes [$];
   frame_byte_type              rsp_want;
   int                          rx_queued = 0;
   int                          rx_accepted = 0;
   int                          bytes_checked = 0;
   int                          frames_seen = 0;
   int                          mismatches = 0;
   int                          idle_cycles = 0;
   bit                          no_gaps = 1'b0;
   int                          hold_req = 0;
   int                          hold_seen = 0;
   int                          hold_left = 0;

   sync_len_checksum_deframer #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
      .clock(clock),
      .reset(reset),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_frame_byte(rsp_frame_byte),
      .rsp_byte_index(rsp_byte_index),
      .rsp_last(rsp_last)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Parses one received byte. A failed frame drops its sync and reparses the bytes behind it.
   function automatic void parse_rx_byte(input logic [slcd_pkg::BYTE_W-1:0] rx);
      logic [slcd_pkg::BYTE_W-1:0] replay_q [$];
      logic [slcd_pkg::BYTE_W-1:0] b;
      int                          p;
      bit                          bad;
      bit                          complete;
      replay_q.push_back(rx);
      while (replay_q.size() != 0) begin
         b = replay_q.pop_front();
         if (frame_fill == 0) begin
            if (b == sync_rx_cfg || b == sync_tx_cfg) begin
               frame_buf[0] = b;
               frame_xor = b;
               frame_fill = 1;
            end
         end else begin
            p = frame_fill;
            frame_buf[p] = b;
            frame_fill = p + 1;
            bad = (p == 1 && b > MAX_PAYLOAD);
            complete = 1'b0;
            if (!bad && p >= 3 && p == int'(frame_buf[1]) + 3) begin
               complete = (b == frame_xor);
               bad = !complete;
            end else if (!bad) begin
               frame_xor = frame_xor ^ b;
            end
            if (complete) begin
               for (int k = 0; k < frame_fill; k++) begin
                  expected_frame_bytes.push_back('{frame_buf[k], slcd_pkg::INDEX_W'(k),
                                                   k == frame_fill - 1});
               end
               frame_fill = 0;
               frame_xor = '0;
            end else if (bad) begin
               for (int k = frame_fill - 1; k >= 1; k--) begin
                  replay_q.push_front(frame_buf[k]);
               end
               frame_fill = 0;
               frame_xor = '0;
            end
         end
      end
   endfunction

   function automatic logic [slcd_pkg::BYTE_W-1:0] pick_sync();
      return $urandom_range(1) ? sync_rx_cfg : sync_tx_cfg;
   endfunction

   task automatic push_rx(input logic [slcd_pkg::BYTE_W-1:0] b);
      rx_pending.push_back(b);
      rx_queued++;
   endtask

   task automatic send_frame(input frame_kind_type kind,
                             input logic [slcd_pkg::BYTE_W-1:0] sync_val, input int len);
      logic [slcd_pkg::BYTE_W-1:0] sum;
      logic [slcd_pkg::BYTE_W-1:0] b;
      int                          n;
      push_rx(sync_val);
      sum = sync_val;
      if (kind == FRAME_LONG) begin
         push_rx(slcd_pkg::BYTE_W'($urandom_range(255, MAX_PAYLOAD + 1)));
         n = $urandom_range(3);
         for (int k = 0; k < n; k++) push_rx(slcd_pkg::BYTE_W'($urandom));
      end else begin
         push_rx(slcd_pkg::BYTE_W'(len));
         sum = sum ^ slcd_pkg::BYTE_W'(len);
         n = (kind == FRAME_CUT) ? $urandom_range(len + 1) : len + 1;
         for (int k = 0; k < n; k++) begin
            b = slcd_pkg::BYTE_W'($urandom);
            push_rx(b);
            sum = sum ^ b;
         end
         if (kind == FRAME_GOOD) begin
            push_rx(sum);
         end else if (kind == FRAME_BAD_SUM) begin
            push_rx(sum ^ (slcd_pkg::BYTE_W'(1) << $urandom_range(slcd_pkg::BYTE_W - 1)));
         end
      end
   endtask

   task automatic write_csr(input logic [slcd_pkg::CSR_IDX_W-1:0] idx,
                            input logic [slcd_pkg::BYTE_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == slcd_pkg::CSR_SYNC_RX) begin
         sync_rx_cfg = val;
      end else begin
         sync_tx_cfg = val;
      end
      @(posedge clock);
   endtask

   // Feeds non-sync bytes until the parser is hunting again, then lets the block drain.
   task automatic settle_block();
      logic [slcd_pkg::BYTE_W-1:0] b;
      while (rx_accepted != rx_queued) @(posedge clock);
      while (frame_fill != 0) begin
         do begin
            b = slcd_pkg::BYTE_W'($urandom_range(255, MAX_PAYLOAD + 1));
         end while (b == sync_rx_cfg || b == sync_tx_cfg);
         push_rx(b);
         while (rx_accepted != rx_queued) @(posedge clock);
      end
      while (expected_frame_bytes.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            parse_rx_byte(req_rx_byte);
            rx_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (rx_pending.size() != 0 && (no_gaps || $urandom_range(99) >= 36)) begin
               req_valid <= 1'b1;
               req_rx_byte <= rx_pending.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_frame_bytes.size() == 0) begin
               $display("%0t: expected no transaction, got byte %02h index %0d last %0b",
                        $time, rsp_frame_byte, rsp_byte_index, rsp_last);
               mismatches++;
            end else begin
               rsp_want = expected_frame_bytes.pop_front();
               if (rsp_frame_byte !== rsp_want.data) begin
                  $display("%0t: frame_byte expected %02h, got %02h",
                           $time, rsp_want.data, rsp_frame_byte);
                  mismatches++;
               end
               if (rsp_byte_index !== rsp_want.index) begin
                  $display("%0t: byte_index expected %0d, got %0d",
                           $time, rsp_want.index, rsp_byte_index);
                  mismatches++;
               end
               if (rsp_last !== rsp_want.last) begin
                  $display("%0t: last expected %0b, got %0b", $time, rsp_want.last, rsp_last);
                  mismatches++;
               end
               bytes_checked++;
               if (rsp_want.last) frames_seen++;
            end
         end
         if (hold_seen != hold_req) begin
            hold_seen <= hold_req;
            hold_left <= HOLD_CYCLES;
         end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
         end
         rsp_stall <= (hold_left > 1) || (hold_seen != hold_req)
                      || (!no_gaps && $urandom_range(99) < 36);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, idle_cycles);
         $display("status: fail");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic [slcd_pkg::BYTE_W-1:0] cfg_a;
      logic [slcd_pkg::BYTE_W-1:0] cfg_b;
      int                          sent;
      int                          pick;
      int                          len;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_rx(8'h00);
      push_rx(8'hFF);
      send_frame(FRAME_GOOD, slcd_pkg::SYNC_RX_RESET, 0);
      send_frame(FRAME_GOOD, slcd_pkg::SYNC_TX_RESET, 1);
      push_rx(slcd_pkg::SYNC_TX_RESET);
      push_rx(slcd_pkg::BYTE_W'(MAX_PAYLOAD + 1));
      send_frame(FRAME_BAD_SUM, slcd_pkg::SYNC_RX_RESET, 0);
      // A sync seen as the length byte fails the first frame and opens the second.
      push_rx(slcd_pkg::SYNC_RX_RESET);
      send_frame(FRAME_GOOD, slcd_pkg::SYNC_RX_RESET, 0);
      settle_block();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: begin
               cfg_a = slcd_pkg::SYNC_RX_RESET;
               cfg_b = slcd_pkg::SYNC_TX_RESET;
            end
            1: begin
               cfg_a = 8'h00;
               cfg_b = 8'hFF;
            end
            2: begin
               cfg_a = 8'hFF;
               cfg_b = 8'h00;
            end
            3: begin
               cfg_a = 8'h5A;
               cfg_b = 8'h5A;
            end
            default: begin
               cfg_a = slcd_pkg::BYTE_W'($urandom);
               cfg_b = slcd_pkg::BYTE_W'($urandom);
            end
         endcase
         if (ph != 0) begin
            write_csr(slcd_pkg::CSR_SYNC_RX, cfg_a);
            write_csr(slcd_pkg::CSR_SYNC_TX, cfg_b);
         end
         no_gaps = (ph == 2);
         if (ph == 1) hold_req++;
         if (ph == 0) send_frame(FRAME_GOOD, pick_sync(), MAX_PAYLOAD);
         sent = 0;
         while (sent < PHASE_BYTES) begin
            pick = $urandom_range(99);
            len = ($urandom_range(99) < 60) ? $urandom_range(3) : $urandom_range(MAX_PAYLOAD);
            if (pick < 62) begin
               send_frame(FRAME_GOOD, pick_sync(), len);
               sent += len + 4;
            end else if (pick < 74) begin
               send_frame(FRAME_BAD_SUM, pick_sync(), len);
               sent += len + 4;
            end else if (pick < 82) begin
               send_frame(FRAME_LONG, pick_sync(), len);
               sent += 2;
            end else if (pick < 90) begin
               send_frame(FRAME_CUT, pick_sync(), len);
               sent += 2;
            end else begin
               repeat ($urandom_range(1, 3)) push_rx(slcd_pkg::BYTE_W'($urandom));
            end
         end
         settle_block();
      end
      no_gaps = 1'b0;

      $display("Sent %0d bytes under five sync settings; checked %0d frame bytes in %0d frames.",
               rx_accepted, bytes_checked, frames_seen);
      if (mismatches == 0 && expected_frame_bytes.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
